[rtl/core/mtes_pkg.sv]
// Shared types, constants and helpers of the MIDI track event serializer.
// Used by the front end, the job queue and the byte sequencer; no dependencies.
package mtes_pkg;

    // Field widths fixed by the item format
    localparam int FIELD_TIME_W = 28;
    localparam int LEN_W        = 28;

    // Job queue between front end and sequencer (power of two)
    localparam int QUEUE_DEPTH = 4;

    // Byte slots of one job, in emission order
    localparam int SLOT_DLT3 = 0;
    localparam int SLOT_DLT0 = 3;
    localparam int SLOT_STAT = 4;
    localparam int SLOT_D0   = 5;
    localparam int SLOT_D1   = 6;
    localparam int SLOT_LEN3 = 7;
    localparam int SLOT_LEN0 = 10;
    localparam int NUM_SLOTS = 11;

    // Status codes and high nibbles
    localparam logic [7:0] STATUS_SYS  = 8'hF0;
    localparam logic [7:0] STATUS_META = 8'hFF;
    localparam logic [3:0] NIB_NOTE_OFF  = 4'h8;
    localparam logic [3:0] NIB_NOTE_ON   = 4'h9;
    localparam logic [3:0] NIB_POLY_AT   = 4'hA;
    localparam logic [3:0] NIB_CTRL      = 4'hB;
    localparam logic [3:0] NIB_PROGRAM   = 4'hC;
    localparam logic [3:0] NIB_CHAN_AT   = 4'hD;
    localparam logic [3:0] NIB_PITCH     = 4'hE;
    localparam logic [3:0] NIB_SYSTEM    = 4'hF;

    // Continuation flag of a VLQ byte
    localparam logic VLQ_MORE = 1'b1;

    // One queued job: which slots to emit and the values behind them
    typedef struct packed {
        logic [NUM_SLOTS-1:0] mask;
        logic [LEN_W-1:0]     delta;
        logic [7:0]           status;
        logic [7:0]           d0;
        logic [6:0]           d1;
        logic [LEN_W-1:0]     plen;
    } t_job;

    // Queue flags seen by the front end and the sequencer
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    // Bit k set when 7-bit group k of the VLQ is present (group 0 always)
    function automatic logic [3:0] vlq_en(input logic [LEN_W-1:0] v);
        logic [3:0] en;
        en[0] = 1'b1;
        en[1] = |v[LEN_W-1:7];
        en[2] = |v[LEN_W-1:14];
        en[3] = |v[LEN_W-1:21];
        return en;
    endfunction

    // Byte of VLQ group k; every group but the lowest carries the more flag
    function automatic logic [7:0] vlq_byte(input logic [LEN_W-1:0] v,
                                            input logic [1:0] k);
        logic [7:0] b;
        unique case (k)
            2'd0: b = {~VLQ_MORE, v[6:0]};
            2'd1: b = {VLQ_MORE, v[13:7]};
            2'd2: b = {VLQ_MORE, v[20:14]};
            2'd3: b = {VLQ_MORE, v[27:21]};
            default: b = '0;
        endcase
        return b;
    endfunction

endpackage

[rtl/core/mtes_front.sv]
// Front end: accepts items, tracks running time and status, builds jobs.
// Depends on mtes_pkg.
module mtes_front #(
    parameter int TIME_BITS = 28
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_accept,
    input  logic                               i_kind,
    input  logic                               i_new_track,
    input  logic [mtes_pkg::FIELD_TIME_W-1:0]  i_event_time,
    input  logic [7:0]                         i_status_byte,
    input  logic [7:0]                         i_data_first,
    input  logic [6:0]                         i_data_second,
    input  logic [mtes_pkg::LEN_W-1:0]         i_payload_len,
    input  logic [7:0]                         i_payload_byte,
    output mtes_pkg::t_job                     o_job
);

    logic [TIME_BITS-1:0] r_time, n_time;
    logic [7:0]           r_status, n_status;

    logic [TIME_BITS-1:0]        base_time;
    logic [7:0]                  base_status;
    logic [TIME_BITS-1:0]        delta;
    logic [mtes_pkg::LEN_W-1:0]  delta_ext;
    logic [3:0]                  dlt_en;
    logic [3:0]                  len_en;
    logic [3:0]                  hi;
    logic                        two_data;
    logic                        one_data;
    logic                        sys_evt;

    // Delta against the previous event, wrapping at TIME_BITS
    always_comb begin
        base_time   = i_new_track ? '0 : r_time;
        base_status = i_new_track ? '0 : r_status;
        delta       = i_event_time[TIME_BITS-1:0] - base_time;
        delta_ext   = mtes_pkg::LEN_W'(delta);
        dlt_en      = mtes_pkg::vlq_en(delta_ext);
        len_en      = mtes_pkg::vlq_en(i_payload_len);
    end

    // Classify by high nibble
    always_comb begin
        hi       = i_status_byte[7:4];
        two_data = 1'b0;
        one_data = 1'b0;
        sys_evt  = 1'b0;
        unique case (hi)
            mtes_pkg::NIB_NOTE_OFF, mtes_pkg::NIB_NOTE_ON, mtes_pkg::NIB_POLY_AT,
            mtes_pkg::NIB_CTRL, mtes_pkg::NIB_PITCH: two_data = 1'b1;
            mtes_pkg::NIB_PROGRAM, mtes_pkg::NIB_CHAN_AT: one_data = 1'b1;
            mtes_pkg::NIB_SYSTEM: sys_evt = 1'b1;
            default: ;
        endcase
    end

    // Job descriptor
    always_comb begin
        o_job        = '0;
        o_job.delta  = delta_ext;
        o_job.d0     = i_data_first;
        o_job.d1     = i_data_second;
        o_job.plen   = i_payload_len;
        if (i_kind) begin
            // payload byte rides in the status slot alone
            o_job.status                   = i_payload_byte;
            o_job.mask[mtes_pkg::SLOT_STAT] = 1'b1;
        end else begin
            o_job.status = i_status_byte;
            for (int k = 0; k < 4; k++) begin
                o_job.mask[mtes_pkg::SLOT_DLT0-k] = dlt_en[k];
                o_job.mask[mtes_pkg::SLOT_LEN0-k] = sys_evt & len_en[k];
            end
            o_job.mask[mtes_pkg::SLOT_STAT] = (i_status_byte != base_status) ||
                                             (i_status_byte >= mtes_pkg::STATUS_SYS);
            o_job.mask[mtes_pkg::SLOT_D0]   = two_data | one_data |
                                             (i_status_byte == mtes_pkg::STATUS_META);
            o_job.mask[mtes_pkg::SLOT_D1]   = two_data;
        end
    end

    // Track state, updated by header items only
    always_comb begin
        n_time   = r_time;
        n_status = r_status;
        if (i_accept && !i_kind) begin
            n_time   = i_event_time[TIME_BITS-1:0];
            n_status = i_status_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time   <= '0;
            r_status <= '0;
        end else begin
            r_time   <= n_time;
            r_status <= n_status;
        end
    end

endmodule

[rtl/core/mtes_queue.sv]
// Short job queue that decouples the front end from the byte sequencer.
// Depends on mtes_pkg.
module mtes_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  mtes_pkg::t_job    i_job,
    input  logic              i_pop,
    output mtes_pkg::t_job    o_job,
    output mtes_pkg::t_q_stat o_stat
);

    localparam int PTR_W = $clog2(mtes_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(mtes_pkg::QUEUE_DEPTH + 1);

    mtes_pkg::t_job r_slots [mtes_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic do_push;
    logic do_pop;

    assign o_stat.full  = (r_cnt == CNT_W'(mtes_pkg::QUEUE_DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign o_job        = r_slots[r_rd];

    assign do_push = i_push && !o_stat.full;
    assign do_pop  = i_pop && !o_stat.empty;

    // Pointers wrap naturally, depth is a power of two
    always_comb begin
        n_wr  = do_push ? r_wr + 1'b1 : r_wr;
        n_rd  = do_pop ? r_rd + 1'b1 : r_rd;
        n_cnt = r_cnt;
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slots[r_wr] <= i_job;
        end
    end

    // Fill level stays within the depth
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(mtes_pkg::QUEUE_DEPTH))
        else $error("queue count over depth");

    // Pointers agree with the fill level
    a_ptr_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        PTR_W'(r_wr - r_rd) == PTR_W'(r_cnt))
        else $error("queue pointers disagree with count");

endmodule

[rtl/core/mtes_back.sv]
// Byte sequencer: walks the slots of each job and drives the output register.
// Depends on mtes_pkg.
module mtes_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mtes_pkg::t_job    i_job,
    input  mtes_pkg::t_q_stat i_q_stat,
    output logic              o_q_pop,
    input  logic              i_pop,
    output logic              o_valid,
    output logic [7:0]        o_byte,
    output logic              o_last
);

    logic                                r_busy, n_busy;
    mtes_pkg::t_job                      r_job, n_job;
    logic                                r_out_valid, n_out_valid;
    logic [7:0]                          r_out_byte, n_out_byte;
    logic                                r_out_last, n_out_last;

    logic [mtes_pkg::NUM_SLOTS-1:0] pick;
    logic [mtes_pkg::NUM_SLOTS-1:0] rest;
    logic [7:0]                     pick_byte;
    logic                           out_free;
    logic                           step;
    logic                           done;
    logic                           take;

    // Byte held by a slot of the current job
    function automatic logic [7:0] slot_byte(input mtes_pkg::t_job j, input int s);
        logic [7:0] b;
        if (s <= mtes_pkg::SLOT_DLT0) begin
            b = mtes_pkg::vlq_byte(j.delta, 2'(mtes_pkg::SLOT_DLT0 - s));
        end else if (s == mtes_pkg::SLOT_STAT) begin
            b = j.status;
        end else if (s == mtes_pkg::SLOT_D0) begin
            b = j.d0;
        end else if (s == mtes_pkg::SLOT_D1) begin
            b = {1'b0, j.d1};
        end else begin
            b = mtes_pkg::vlq_byte(j.plen, 2'(mtes_pkg::SLOT_LEN0 - s));
        end
        return b;
    endfunction

    // Lowest pending slot goes next
    always_comb begin
        pick      = r_job.mask & (~r_job.mask + 1'b1);
        rest      = r_job.mask & ~pick;
        pick_byte = '0;
        for (int s = 0; s < mtes_pkg::NUM_SLOTS; s++) begin
            pick_byte = pick_byte | ({8{pick[s]}} & slot_byte(r_job, s));
        end
    end

    assign out_free = !r_out_valid || i_pop;
    assign step     = r_busy && out_free;
    assign done     = step && (rest == '0);
    assign take     = (!r_busy || done) && !i_q_stat.empty;
    assign o_q_pop  = take;

    // Job register and output register
    always_comb begin
        n_busy      = r_busy;
        n_job       = r_job;
        n_out_valid = r_out_valid;
        n_out_byte  = r_out_byte;
        n_out_last  = r_out_last;
        if (take) begin
            n_busy = 1'b1;
            n_job  = i_job;
        end else if (step) begin
            n_job.mask = rest;
            if (done) begin
                n_busy = 1'b0;
            end
        end
        if (step) begin
            n_out_valid = 1'b1;
            n_out_byte  = pick_byte;
            n_out_last  = (rest == '0);
        end else if (i_pop) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job      <= n_job;
        r_out_byte <= n_out_byte;
        r_out_last <= n_out_last;
    end

    assign o_valid = r_out_valid;
    assign o_byte  = r_out_byte;
    assign o_last  = r_out_last;

    // A live job always has a byte left
    a_busy_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_job.mask != '0))
        else $error("busy with empty slot mask");

    // A loaded job is being worked on next cycle
    a_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take |=> r_busy)
        else $error("job taken but sequencer idle");

    // A byte not taken is never dropped
    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_pop) |=> r_out_valid)
        else $error("output byte lost");

endmodule

[rtl/core/midi_track_event_serializer.sv]
// Top level of the MIDI track event serializer: front end, job queue, sequencer.
// Depends on mtes_pkg, mtes_front, mtes_queue and mtes_back.
//
//   channel  | handshake        | payload
//   ---------+------------------+----------------------------------------------
//   input    | push / full      | i_kind, i_new_track, i_event_time, ...
//   result   | pop / empty      | o_out_byte, o_last
//
// One output byte per cycle while jobs are queued and the result side keeps popping;
// a header item yields 1 to 10 bytes, a payload item one byte.
// Items are accepted every cycle while the four-entry job queue has room.
// An item's first byte passes the job queue, job register and output register.
// Reset is synchronous, active low; clears running time, last status, queue, sequencer.
// A stalled result holds the sequencer; the queue absorbs incoming items.
module midi_track_event_serializer #(
    parameter int TIME_BITS = 28
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic        i_kind,
    input  logic        i_new_track,
    input  logic [27:0] i_event_time,
    input  logic [7:0]  i_status_byte,
    input  logic [7:0]  i_data_first,
    input  logic [6:0]  i_data_second,
    input  logic [27:0] i_payload_len,
    input  logic [7:0]  i_payload_byte,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  o_out_byte,
    output logic        o_last
);

    mtes_pkg::t_job    front_job;
    mtes_pkg::t_job    q_job;
    mtes_pkg::t_q_stat q_stat;
    logic              accept;
    logic              q_pop;
    logic              out_valid;

    assign accept = push && !q_stat.full;
    assign full   = q_stat.full;
    assign empty  = !out_valid;

    mtes_front #(
        .TIME_BITS (TIME_BITS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_kind         (i_kind),
        .i_new_track    (i_new_track),
        .i_event_time   (i_event_time),
        .i_status_byte  (i_status_byte),
        .i_data_first   (i_data_first),
        .i_data_second  (i_data_second),
        .i_payload_len  (i_payload_len),
        .i_payload_byte (i_payload_byte),
        .o_job          (front_job)
    );

    mtes_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_job   (front_job),
        .i_pop   (q_pop),
        .o_job   (q_job),
        .o_stat  (q_stat)
    );

    mtes_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_job    (q_job),
        .i_q_stat (q_stat),
        .o_q_pop  (q_pop),
        .i_pop    (pop),
        .o_valid  (out_valid),
        .o_byte   (o_out_byte),
        .o_last   (o_last)
    );

endmodule

[tb/tb_midi_track_event_serializer.sv]
// Self-checking bench for midi_track_event_serializer: queued stimulus, byte predictor,
// randomly stalled result side. Depends on mtes_pkg and the serializer RTL.
module tb_midi_track_event_serializer;

    // Item kind codes
    localparam logic KIND_HEADER  = 1'b0;
    localparam logic KIND_PAYLOAD = 1'b1;

    localparam int RANDOM_TARGET = 330;
    localparam int DRAIN_CYCLES  = 20;

    typedef struct packed {
        logic        kind;
        logic        new_track;
        logic [27:0] event_time;
        logic [7:0]  status;
        logic [7:0]  d0;
        logic [6:0]  d1;
        logic [27:0] plen;
        logic [7:0]  pbyte;
    } t_midi_item;

    typedef struct packed {
        logic [7:0] value;
        logic       last;
    } t_track_byte;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic        i_kind = 1'b0;
    logic        i_new_track = 1'b0;
    logic [27:0] i_event_time = '0;
    logic [7:0]  i_status_byte = 8'h80;
    logic [7:0]  i_data_first = '0;
    logic [6:0]  i_data_second = '0;
    logic [27:0] i_payload_len = '0;
    logic [7:0]  i_payload_byte = '0;
    logic        empty;
    logic        pop = 1'b0;
    logic [7:0]  o_out_byte;
    logic        o_last;

    midi_track_event_serializer dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_kind         (i_kind),
        .i_new_track    (i_new_track),
        .i_event_time   (i_event_time),
        .i_status_byte  (i_status_byte),
        .i_data_first   (i_data_first),
        .i_data_second  (i_data_second),
        .i_payload_len  (i_payload_len),
        .i_payload_byte (i_payload_byte),
        .empty          (empty),
        .pop            (pop),
        .o_out_byte     (o_out_byte),
        .o_last         (o_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_midi_item  pending_items[$];
    t_track_byte expected_bytes[$];
    logic [7:0]  enc_bytes[$];
    int          items_total = 0;
    int          items_accepted = 0;
    int          fail_count = 0;

    // Predictor state: time and status of the previous header
    logic [27:0] track_time = '0;
    logic [7:0]  track_status = '0;

    function automatic void append_vlq(input logic [27:0] v);
        int          groups;
        logic [27:0] rest;
        groups = 1;
        rest = v >> 7;
        while (rest != 0 && groups < 4) begin
            groups++;
            rest = rest >> 7;
        end
        for (int k = groups - 1; k >= 0; k--) begin
            enc_bytes.push_back({(k > 0), 7'(v >> (7 * k))});
        end
    endfunction

    // Track bytes caused by one accepted item, queued as expectations
    function automatic void encode_track_bytes(input t_midi_item it);
        logic [27:0] delta;
        t_track_byte tb;
        enc_bytes.delete();
        if (it.kind == KIND_PAYLOAD) begin
            // payload byte passes through; state untouched
            enc_bytes.push_back(it.pbyte);
        end else begin
            if (it.new_track) begin
                track_time = '0;
                track_status = '0;
            end
            delta = it.event_time - track_time;   // wraps at 28 bits
            track_time = it.event_time;
            append_vlq(delta);
            // running status applies below system range only
            if (it.status != track_status || it.status >= mtes_pkg::STATUS_SYS) begin
                enc_bytes.push_back(it.status);
            end
            track_status = it.status;
            case (it.status[7:4])
                mtes_pkg::NIB_NOTE_OFF, mtes_pkg::NIB_NOTE_ON, mtes_pkg::NIB_POLY_AT,
                mtes_pkg::NIB_CTRL, mtes_pkg::NIB_PITCH: begin
                    enc_bytes.push_back(it.d0);
                    enc_bytes.push_back({1'b0, it.d1});
                end
                mtes_pkg::NIB_PROGRAM, mtes_pkg::NIB_CHAN_AT: begin
                    enc_bytes.push_back(it.d0);
                end
                mtes_pkg::NIB_SYSTEM: begin
                    if (it.status == mtes_pkg::STATUS_META) begin
                        enc_bytes.push_back(it.d0);
                    end
                    append_vlq(it.plen);
                end
                default: ;   // invalid status: no data bytes
            endcase
        end
        for (int i = 0; i < enc_bytes.size(); i++) begin
            tb.value = enc_bytes[i];
            tb.last = (i == enc_bytes.size() - 1);
            expected_bytes.push_back(tb);
        end
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH t=%0t %s: got 0x%0h want 0x%0h", $realtime, what, got, want);
        fail_count++;
    endtask

    // Mostly back-to-back, some short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 94) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Stimulus builders
    task automatic add_header(input logic nt, input logic [27:0] t, input logic [7:0] st,
                              input logic [7:0] d0, input logic [6:0] d1,
                              input logic [27:0] plen);
        t_midi_item it;
        it.kind = KIND_HEADER;
        it.new_track = nt;
        it.event_time = t;
        it.status = st;
        it.d0 = d0;
        it.d1 = d1;
        it.plen = plen;
        it.pbyte = 8'($urandom);
        pending_items.push_back(it);
    endtask

    task automatic add_payload(input logic [7:0] b);
        t_midi_item it;
        it.kind = KIND_PAYLOAD;
        it.new_track = 1'($urandom);
        it.event_time = 28'($urandom);
        it.status = 8'($urandom);
        it.d0 = 8'($urandom);
        it.d1 = 7'($urandom);
        it.plen = 28'($urandom);
        it.pbyte = b;
        pending_items.push_back(it);
    endtask

    // Driver: one item per push handshake, random gaps between items
    t_midi_item cur_item;
    int         push_gap = 0;
    int         push_burst = 0;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (push && !full) begin
                encode_track_bytes(cur_item);
                items_accepted++;
            end
            if (!(push && full)) begin
                if (push_gap > 0) begin
                    push_gap--;
                    push <= 1'b0;
                end else if (pending_items.size() > 0) begin
                    cur_item = pending_items.pop_front();
                    i_kind <= cur_item.kind;
                    i_new_track <= cur_item.new_track;
                    i_event_time <= cur_item.event_time;
                    i_status_byte <= cur_item.status;
                    i_data_first <= cur_item.d0;
                    i_data_second <= cur_item.d1;
                    i_payload_len <= cur_item.plen;
                    i_payload_byte <= cur_item.pbyte;
                    push <= 1'b1;
                    if (push_burst > 0) begin
                        push_burst--;
                        push_gap = 0;
                    end else begin
                        push_gap = pick_gap();
                        if ($urandom_range(0, 49) == 0) push_burst = $urandom_range(20, 60);
                    end
                end else begin
                    push <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each popped byte against the oldest expectation
    t_track_byte got_exp;
    int          pop_gap = 0;
    int          pop_burst = 0;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (pop && !empty) begin
                if (expected_bytes.size() == 0) begin
                    report_mismatch("byte with nothing pending", int'(o_out_byte), 0);
                end else begin
                    got_exp = expected_bytes.pop_front();
                    if (o_out_byte !== got_exp.value)
                        report_mismatch("out_byte", int'(o_out_byte), int'(got_exp.value));
                    if (o_last !== got_exp.last)
                        report_mismatch("last", int'(o_last), int'(got_exp.last));
                end
            end
            if (pop_gap > 0) begin
                pop_gap--;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
                if (pop_burst > 0) begin
                    pop_burst--;
                end else begin
                    pop_gap = pick_gap();
                    if ($urandom_range(0, 49) == 0) pop_burst = $urandom_range(20, 60);
                end
            end
        end
    end

    // Stimulus, reset and end of run
    logic [27:0] gen_time;
    logic [7:0]  gen_chan;
    logic [7:0]  gen_status;
    logic [27:0] gen_len;
    logic        gen_nt;
    logic        gen_sys;
    int          roll;
    int          follow;

    initial begin
        // Directed: VLQ sizes, every status group, running status, system/meta
        add_header(1'b1, 28'd0, 8'h90, 8'hFF, 7'h7F, 28'd5);         // zero delta
        add_header(1'b0, 28'h7F, 8'h90, 8'h00, 7'h00, 28'd0);         // running status
        add_header(1'b0, 28'hFF, 8'h80, 8'h3C, 7'h40, 28'd0);         // two-byte delta
        add_header(1'b0, 28'h40FF, 8'hA5, 8'hAA, 7'h55, 28'd0);       // three-byte delta
        add_header(1'b0, 28'h40FE, 8'hB3, 8'h55, 7'h2A, 28'd0);       // backward: wraps
        add_header(1'b0, 28'h40FE, 8'hC2, 8'h00, 7'h7F, 28'd9);
        add_header(1'b0, 28'h4200, 8'hD7, 8'h81, 7'h01, 28'd0);
        add_header(1'b0, 28'h4300, 8'hEF, 8'h80, 7'h7F, 28'd0);
        add_header(1'b0, 28'h4301, 8'hFF, 8'h51, 7'h00, 28'd3);       // meta with payload
        add_payload(8'h00);
        add_payload(8'hFF);
        add_payload(8'h5A);
        add_header(1'b0, 28'h4301, 8'h90, 8'h40, 7'h40, 28'd0);       // status after meta
        add_header(1'b0, 28'h4310, 8'hF0, 8'h12, 7'h00, 28'd0);       // empty sysex
        add_header(1'b0, 28'h4310, 8'hF0, 8'h12, 7'h00, 28'd0);       // repeated F0 still sent
        add_header(1'b0, 28'h4400, 8'hF7, 8'h00, 7'h00, 28'd2);
        add_payload(8'hA5);
        add_payload(8'h5A);
        add_header(1'b0, 28'h4401, 8'hFF, 8'h2F, 7'h00, 28'hFFFFFFF); // four-byte length
        add_header(1'b0, 28'h4402, 8'h40, 8'hFF, 7'h7F, 28'd0);       // invalid status
        add_header(1'b0, 28'h4403, 8'h40, 8'hFF, 7'h7F, 28'd0);       // invalid, running
        add_header(1'b1, 28'h0000010, 8'h00, 8'h00, 7'h00, 28'd0);    // status equal to cleared
        add_payload(8'hC3);
        add_header(1'b1, 28'hFFFFFFF, 8'hF5, 8'hFF, 7'h7F, 28'h3FFF);

        // Random: mostly well-formed tracks, some stray payload and odd times
        gen_time = 28'hFFFFFFF;
        gen_chan = 8'h00;
        while (pending_items.size() < RANDOM_TARGET) begin
            roll = $urandom_range(0, 99);
            if (roll < 3) begin
                add_payload(8'($urandom));
            end else begin
                gen_nt = ($urandom_range(0, 99) < 5);
                if (gen_nt) begin
                    gen_time = '0;
                    gen_chan = 8'h00;
                end
                roll = $urandom_range(0, 99);
                if (roll < 50) gen_time = gen_time + 28'($urandom_range(0, 127));
                else if (roll < 75) gen_time = gen_time + 28'($urandom_range(128, 16383));
                else if (roll < 87) gen_time = gen_time + 28'($urandom_range(16384, 2097151));
                else if (roll < 95) gen_time = gen_time + 28'($urandom);
                else gen_time = 28'($urandom);                         // jump anywhere
                gen_sys = 1'b0;
                roll = $urandom_range(0, 99);
                if (roll < 3) begin
                    gen_status = 8'($urandom_range(0, 127));
                end else if (roll < 18) begin
                    gen_sys = 1'b1;
                    if ($urandom_range(0, 1)) gen_status = mtes_pkg::STATUS_META;
                    else gen_status = mtes_pkg::STATUS_SYS | 8'($urandom_range(0, 15));
                end else if (roll < 60 && gen_chan != 8'h00) begin
                    gen_status = gen_chan;
                end else begin
                    gen_status = 8'($urandom_range(8'h80, 8'hEF));
                    gen_chan = gen_status;
                end
                follow = 0;
                if (gen_sys && $urandom_range(0, 9) != 0) begin
                    follow = $urandom_range(0, 6);
                    gen_len = 28'(follow);
                end else begin
                    gen_len = 28'($urandom);
                end
                add_header(gen_nt, gen_time, gen_status, 8'($urandom), 7'($urandom), gen_len);
                for (int i = 0; i < follow; i++) add_payload(8'($urandom));
            end
        end
        items_total = pending_items.size();

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (items_accepted < items_total) @(posedge i_clk);
        while (expected_bytes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("midi_track_event_serializer verification clean");
        end else begin
            $display("midi_track_event_serializer verification failed");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #5000000;
        $display("midi_track_event_serializer verification failed");
        $finish;
    end

endmodule
